// ===== hw/rtl/loss_based_bitrate_estimator_core_defines.svh =====
// Assertion macros shared by the bitrate estimator RTL.
// Depends on nothing; every macro expects clk and rst_n in scope.
`ifndef LOSS_BASED_BITRATE_ESTIMATOR_CORE_DEFINES_SVH
`define LOSS_BASED_BITRATE_ESTIMATOR_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LBBE_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define LBBE_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define LBBE_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LBBE_CHECK(lbl, expr, msg)
`define LBBE_IMPLY(lbl, ante, cons, msg)
`define LBBE_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/lbbe_pkg.sv =====
// Types, constants and helpers of the loss-based bitrate estimator.
// Used by every module of the block; depends on nothing.
package lbbe_pkg;

  localparam int SEQ_BITS   = 16;
  localparam int SIZE_BITS  = 16;
  localparam int TIME_BITS  = 48;
  localparam int COUNT_BITS = 16;
  localparam int EPOCH_BITS = 4;
  localparam int SEQ_DEPTH  = 1 << SEQ_BITS;

  localparam int DIV_NW = 64;
  localparam int DIV_DW = TIME_BITS;
  localparam int DIV_CW = $clog2(DIV_NW);

  localparam int RATE_W = 55;
  localparam logic [22:0] RATE_SCALE = 23'd8000000;
  localparam logic [TIME_BITS-1:0] MIN_DT = TIME_BITS'(1000);

  localparam logic [16:0] Q_ONE  = 17'd65536;
  localparam logic [16:0] W_RISE = 17'd22938;
  localparam logic [16:0] W_FALL = 17'd36045;
  localparam logic [16:0] W_030  = 17'd19661;
  localparam logic [16:0] W_035  = 17'd22938;
  localparam logic [16:0] W_055  = 17'd36045;
  localparam logic [16:0] W_070  = 17'd45875;
  localparam logic [16:0] M_050  = 17'd32768;
  localparam logic [16:0] M_070  = 17'd45875;
  localparam logic [16:0] M_085  = 17'd55706;
  localparam logic [16:0] M_105  = 17'd68813;

  localparam logic [31:0] RST_MIN   = 32'd30000;
  localparam logic [31:0] RST_MAX   = 32'd2500000;
  localparam logic [31:0] RST_START = 32'd300000;

  typedef enum logic [1:0] {
    KIND_SENT  = 2'd0,
    KIND_FB    = 2'd1,
    KIND_ROUTE = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_MIN_RATE  = 2'd0,
    CFG_MAX_RATE  = 2'd1,
    CFG_START     = 2'd2,
    CFG_OWN_ID    = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CMD_SENT  = 3'd0,
    CMD_FB    = 3'd1,
    CMD_ROUTE = 3'd2,
    CMD_NOP   = 3'd3,
    CMD_BADID = 3'd4
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t              op;
    logic [SEQ_BITS-1:0]  seq;
    logic [15:0]          bytes;
    logic                 rcv;
    logic [TIME_BITS-1:0] t;
    logic                 last;
    logic [31:0]          nstart;
  } cmd_t;

  function automatic logic [31:0] clamp_rate(input logic [31:0] v,
                                             input logic [31:0] lo,
                                             input logic [31:0] hi);
    logic [31:0] r;
    r = (v < hi) ? v : hi;
    if (r < lo) begin
      r = lo;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/lbbe_front.sv =====
// Front end: accepts input transactions, classifies them and queues commands.
// Depends on lbbe_pkg.
module lbbe_front import lbbe_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,  // seq_num, packet_bytes, received, recv_time_us,
                                  // report_transport_id, new_start_bps, zero pad
  input  logic [1:0]   in_tuser,  // kind
  input  logic         in_tlast,  // last_in_report
  input  logic [15:0]  own_id,
  output logic         cmd_valid,
  output cmd_t         cmd,
  input  logic         cmd_pop
);

  cmd_t        q_r [0:1];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  cmd_t        cmd_in;
  logic        push;

  always_comb begin
    cmd_in.seq    = in_tdata[SEQ_BITS-1:0];
    cmd_in.bytes  = in_tdata[31:16];
    cmd_in.rcv    = in_tdata[32];
    cmd_in.t      = in_tdata[33 +: TIME_BITS];
    cmd_in.last   = in_tlast;
    cmd_in.nstart = in_tdata[128:97];
    case (kind_t'(in_tuser))
      KIND_SENT:  cmd_in.op = CMD_SENT;
      KIND_FB:    cmd_in.op = (in_tdata[96:81] == own_id) ? CMD_FB : CMD_BADID;
      KIND_ROUTE: cmd_in.op = CMD_ROUTE;
      default:    cmd_in.op = CMD_NOP;
    endcase
  end

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (cmd_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, cmd_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== hw/rtl/lbbe_div.sv =====
// Restoring divider that retires one quotient bit per cycle.
// Depends on lbbe_pkg for its widths.
module lbbe_div import lbbe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic              done,
  output logic [DIV_NW-1:0] quotient
);

  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] div_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial    = {rem_r, quo_r[DIV_NW-1]};
  assign fits     = (trial >= {1'b0, div_r});
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      div_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? DIV_DW'(trial - {1'b0, div_r}) : trial[DIV_DW-1:0];
      quo_r <= {quo_r[DIV_NW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CW'(DIV_NW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/lbbe_back.sv =====
// Back end: executes queued commands, holds the size table, the report
// accumulators, the estimator state and the output register.
// Depends on lbbe_pkg, lbbe_div and loss_based_bitrate_estimator_core_defines.svh.
`include "loss_based_bitrate_estimator_core_defines.svh"
module lbbe_back import lbbe_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output logic [15:0]  own_id,
  input  logic         cmd_valid,
  input  cmd_t         cmd,
  output logic         cmd_pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic         out_status,
  output logic         out_updated,
  output logic [31:0]  out_estimate,
  output logic [16:0]  out_loss,
  output logic [16:0]  out_smooth
);

  typedef enum logic [3:0] {
    ST_SWEEP, ST_IDLE, ST_FB_RD, ST_FB_ACC, ST_CL_START, ST_WAIT_LOSS, ST_SMOOTH,
    ST_RATE, ST_RATE_DIV, ST_WAIT_RATE, ST_DEC, ST_CALC2, ST_FIN
  } state_t;

  localparam int MW = EPOCH_BITS + SIZE_BITS;
  localparam int THR_W = COUNT_BITS + 6;

  state_t                state_r;
  logic [31:0]           min_r, max_r;
  logic [15:0]           own_id_r;
  logic [31:0]           est_r;
  logic [16:0]           loss_r, smooth_r;
  logic                  have_r;
  logic [COUNT_BITS-1:0] rep_r, lost_r;
  logic [31:0]           acked_r;
  logic [TIME_BITS-1:0]  first_r, latest_r;
  logic                  seen_r;
  logic [EPOCH_BITS-1:0] epoch_r;
  logic [SEQ_BITS-1:0]   sweep_addr_r;
  cmd_t                  cmd_r;
  logic                  has_rate_r;
  logic [31:0]           recv_r;
  logic [RATE_W-1:0]     rmul_r;
  logic [48:0]           prod_r;
  logic [49:0]           sum_r;
  logic [16:0]           wb_r;
  logic                  out_valid_r, out_status_r, out_updated_r;
  logic [31:0]           out_est_r;
  logic [16:0]           out_loss_r, out_smooth_r;

  logic [MW-1:0]         mem [0:SEQ_DEPTH-1];
  logic [MW-1:0]         mem_rd_r;
  logic                  mem_we;
  logic [SEQ_BITS-1:0]   mem_waddr;
  logic [MW-1:0]         mem_wdata;

  logic                  div_start, div_done;
  logic [DIV_NW-1:0]     div_a, div_q;
  logic [DIV_DW-1:0]     div_b;

  logic                  hit;
  logic [32:0]           acked_sum;
  logic [31:0]           add_bytes;
  logic [TIME_BITS-1:0]  dt, dtc;
  logic [THR_W-1:0]      lost20, lost50, rep6, rep3, rep1;
  logic                  rep_nz;
  logic [16:0]           w_sm, mul_a, wb, w_bl;
  logic [34:0]           sm_sum;
  logic [33:0]           fin_v;
  logic [31:0]           fin_sat, est_new, route_est;
  logic [31:0]           recv_sat;

  assign own_id      = own_id_r;
  assign out_tvalid  = out_valid_r;
  assign out_status  = out_status_r;
  assign out_updated = out_updated_r;
  assign out_estimate = out_est_r;
  assign out_loss    = out_loss_r;
  assign out_smooth  = out_smooth_r;
  assign cmd_pop     = (state_r == ST_IDLE) && cmd_valid && (!out_valid_r || out_tready);

  assign hit       = (mem_rd_r[MW-1:SIZE_BITS] == epoch_r);
  assign add_bytes = hit ? 32'(mem_rd_r[SIZE_BITS-1:0]) : 32'(cmd_r.bytes);
  assign acked_sum = {1'b0, acked_r} + {1'b0, add_bytes};
  assign dt        = latest_r - first_r;
  assign dtc       = (dt < MIN_DT) ? MIN_DT : dt;
  assign rep_nz    = (rep_r != '0);
  assign lost20    = THR_W'(lost_r) * THR_W'(20);
  assign lost50    = THR_W'(lost_r) * THR_W'(50);
  assign rep6      = THR_W'(rep_r) * THR_W'(6);
  assign rep3      = THR_W'(rep_r) * THR_W'(3);
  assign rep1      = THR_W'(rep_r);
  assign w_sm      = (loss_r > smooth_r) ? W_RISE : W_FALL;
  assign sm_sum    = 35'(34'(smooth_r) * 34'(Q_ONE - w_sm)) + 35'(34'(loss_r) * 34'(w_sm));
  assign recv_sat  = (div_q[DIV_NW-1:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
  assign fin_v     = sum_r[49:16];
  assign fin_sat   = (fin_v[33:32] != 2'b00) ? 32'hFFFF_FFFF : fin_v[31:0];
  assign est_new   = clamp_rate(fin_sat, min_r, max_r);
  assign route_est = clamp_rate(cmd.nstart, min_r, max_r);

  always_comb begin
    if (recv_r < (est_r >> 2)) begin
      w_bl = W_070;
    end else if (recv_r < (est_r >> 1)) begin
      w_bl = W_055;
    end else if (recv_r >= est_r) begin
      w_bl = W_030;
    end else begin
      w_bl = W_035;
    end
    wb = '0;
    if (rep_nz && lost20 >= rep6) begin
      mul_a = M_050;
    end else if (rep_nz && lost20 >= rep3) begin
      mul_a = M_070;
    end else if (rep_nz && lost20 >= rep1) begin
      mul_a = M_085;
    end else if (has_rate_r) begin
      mul_a = Q_ONE - w_bl;
      wb    = w_bl;
    end else if (!rep_nz || lost50 < rep1) begin
      mul_a = M_105;
    end else begin
      mul_a = Q_ONE;
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_a     = DIV_NW'({lost_r, 16'b0});
    div_b     = DIV_DW'(rep_r);
    if (state_r == ST_CL_START && rep_nz) begin
      div_start = 1'b1;
    end else if (state_r == ST_RATE_DIV) begin
      div_start = 1'b1;
      div_a     = DIV_NW'(rmul_r);
      div_b     = dtc;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cmd_r.seq;
    mem_wdata = '0;
    if (state_r == ST_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_addr_r;
    end else if (cmd_pop && cmd.op == CMD_SENT) begin
      mem_we    = 1'b1;
      mem_waddr = cmd.seq;
      mem_wdata = {epoch_r, cmd.bytes[SIZE_BITS-1:0]};
    end else if (state_r == ST_FB_ACC && hit) begin
      mem_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_r <= mem[cmd_r.seq];
  end

  lbbe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r <= cmd;
    end
    case (state_r)
      ST_RATE:  rmul_r <= RATE_W'(acked_r) * RATE_W'(RATE_SCALE);
      ST_DEC: begin
        prod_r <= 49'(est_r) * 49'(mul_a);
        wb_r   <= wb;
      end
      ST_CALC2: sum_r <= 50'(prod_r) + 50'(49'(recv_r) * 49'(wb_r));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      sweep_addr_r <= '0;
      epoch_r      <= EPOCH_BITS'(1);
      min_r        <= RST_MIN;
      max_r        <= RST_MAX;
      own_id_r     <= '0;
      est_r        <= RST_START;
      loss_r       <= '0;
      smooth_r     <= '0;
      have_r       <= 1'b0;
      rep_r        <= '0;
      lost_r       <= '0;
      acked_r      <= '0;
      first_r      <= '0;
      latest_r     <= '0;
      seen_r       <= 1'b0;
      has_rate_r   <= 1'b0;
      recv_r       <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= 1'b0;
      out_updated_r <= 1'b0;
      out_est_r    <= '0;
      out_loss_r   <= '0;
      out_smooth_r <= '0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_SWEEP: begin
          sweep_addr_r <= sweep_addr_r + 1'b1;
          if (sweep_addr_r == '1) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_pop) begin
            if (cmd.op == CMD_FB) begin
              state_r <= ST_FB_RD;
            end else begin
              out_valid_r   <= 1'b1;
              out_status_r  <= (cmd.op == CMD_BADID);
              out_updated_r <= 1'b0;
              out_est_r     <= est_r;
              out_loss_r    <= loss_r;
              out_smooth_r  <= smooth_r;
              if (cmd.op == CMD_ROUTE) begin
                est_r        <= route_est;
                out_est_r    <= route_est;
                smooth_r     <= '0;
                out_smooth_r <= '0;
                have_r       <= 1'b0;
                rep_r        <= '0;
                lost_r       <= '0;
                acked_r      <= '0;
                first_r      <= '0;
                latest_r     <= '0;
                seen_r       <= 1'b0;
                if (epoch_r == '1) begin
                  epoch_r <= EPOCH_BITS'(1);
                  state_r <= ST_SWEEP;
                end else begin
                  epoch_r <= epoch_r + 1'b1;
                end
              end
            end
          end
        end
        ST_FB_RD: begin
          if (rep_r != '1) begin
            rep_r <= rep_r + 1'b1;
          end
          if (cmd_r.rcv) begin
            state_r <= ST_FB_ACC;
          end else begin
            if (lost_r != '1) begin
              lost_r <= lost_r + 1'b1;
            end
            if (cmd_r.last) begin
              state_r <= ST_CL_START;
            end else begin
              state_r       <= ST_IDLE;
              out_valid_r   <= 1'b1;
              out_status_r  <= 1'b0;
              out_updated_r <= 1'b0;
              out_est_r     <= est_r;
              out_loss_r    <= loss_r;
              out_smooth_r  <= smooth_r;
            end
          end
        end
        ST_FB_ACC: begin
          acked_r <= acked_sum[32] ? 32'hFFFF_FFFF : acked_sum[31:0];
          if (!seen_r || cmd_r.t < first_r) begin
            first_r <= cmd_r.t;
          end
          if (!seen_r || cmd_r.t > latest_r) begin
            latest_r <= cmd_r.t;
          end
          seen_r <= 1'b1;
          if (cmd_r.last) begin
            state_r <= ST_CL_START;
          end else begin
            state_r       <= ST_IDLE;
            out_valid_r   <= 1'b1;
            out_status_r  <= 1'b0;
            out_updated_r <= 1'b0;
            out_est_r     <= est_r;
            out_loss_r    <= loss_r;
            out_smooth_r  <= smooth_r;
          end
        end
        ST_CL_START: begin
          has_rate_r <= (acked_r != '0) && seen_r && (latest_r > first_r);
          state_r    <= rep_nz ? ST_WAIT_LOSS : ST_RATE;
        end
        ST_WAIT_LOSS: begin
          if (div_done) begin
            loss_r  <= div_q[16:0];
            state_r <= ST_SMOOTH;
          end
        end
        ST_SMOOTH: begin
          smooth_r <= have_r ? sm_sum[32:16] : loss_r;
          have_r   <= 1'b1;
          state_r  <= ST_RATE;
        end
        ST_RATE: begin
          if (has_rate_r) begin
            state_r <= ST_RATE_DIV;
          end else begin
            recv_r  <= '0;
            state_r <= ST_DEC;
          end
        end
        ST_RATE_DIV: state_r <= ST_WAIT_RATE;
        ST_WAIT_RATE: begin
          if (div_done) begin
            recv_r  <= recv_sat;
            state_r <= ST_DEC;
          end
        end
        ST_DEC:   state_r <= ST_CALC2;
        ST_CALC2: state_r <= ST_FIN;
        ST_FIN: begin
          est_r         <= est_new;
          rep_r         <= '0;
          lost_r        <= '0;
          acked_r       <= '0;
          first_r       <= '0;
          latest_r      <= '0;
          seen_r        <= 1'b0;
          state_r       <= ST_IDLE;
          out_valid_r   <= 1'b1;
          out_status_r  <= 1'b0;
          out_updated_r <= 1'b1;
          out_est_r     <= est_new;
          out_loss_r    <= loss_r;
          out_smooth_r  <= smooth_r;
        end
        default: state_r <= ST_IDLE;
      endcase
      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MIN_RATE: min_r <= cfg_data;
          CFG_MAX_RATE: max_r <= cfg_data;
          CFG_START:    est_r <= cfg_data;
          CFG_OWN_ID:   own_id_r <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  `LBBE_CHECK(a_epoch_nonzero, epoch_r != '0, "size table epoch reached the cleared tag")
  `LBBE_CHECK(a_lost_le_reported, lost_r <= rep_r, "lost count exceeds reported count")
  `LBBE_IMPLY(a_pop_has_room, cmd_pop, cmd_valid && (!out_valid_r || out_tready), "popped without room")
  `LBBE_NEXT(a_fin_floor, state_r == ST_FIN, est_r >= min_r, "estimate below lower clamp")

endmodule

// ===== hw/rtl/loss_based_bitrate_estimator_core.sv =====
// Top level of the loss-based bitrate estimator: front end, command queue and back end.
// Depends on lbbe_pkg, lbbe_front and lbbe_back.
//
//   Channel  Direction  Handshake           Payload
//   in_      slave      in_tvalid/tready    tdata 136 b, tuser kind, tlast last_in_report
//   out_     master     out_tvalid/tready   tdata 104 b, tuser status and updated
//   cfg_     slave      cfg_valid/ready     cfg_index 2 b, cfg_data 32 b
//
// The back end takes a queued command when it is idle and the output register is free; a sent,
// mismatched, ignored or route-change item loads the output register as it is taken. A lost feedback
// entry passes through FB_RD first, a received one through FB_RD and FB_ACC. An entry that closes a
// report runs, as they apply, the loss division, smoothing, rate division and final multiply-add,
// spending most time in up to two 64-step passes of the shared bit-serial divider. A route
// change that wraps the 4-bit table epoch clears the size table, as does reset; the two-entry
// queue keeps accepting until it fills. Reset is synchronous; the output holds until taken.
module loss_based_bitrate_estimator_core import lbbe_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // seq_num, packet_bytes, received, recv_time_us,
                                   // report_transport_id, new_start_bps, zero pad
  input  logic [1:0]   in_tuser,   // kind
  input  logic         in_tlast,   // last_in_report
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // estimate_bps, pacing_bps, loss_q16,
                                   // smoothed_loss_q16, zero pad
  output logic [1:0]   out_tuser,  // status, updated
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic        cmd_valid;
  logic        cmd_pop;
  cmd_t        cmd;
  logic [15:0] own_id;
  logic        status;
  logic        updated;
  logic [31:0] estimate;
  logic [16:0] loss;
  logic [16:0] smooth;

  assign cfg_ready = 1'b1;
  assign out_tdata = {6'b0, smooth, loss, estimate, estimate};
  assign out_tuser = {updated, status};

  lbbe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .own_id    (own_id),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  lbbe_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .own_id       (own_id),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_status   (status),
    .out_updated  (updated),
    .out_estimate (estimate),
    .out_loss     (loss),
    .out_smooth   (smooth)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for loss_based_bitrate_estimator_core: directed and random
// packet, feedback and route traffic against an in-bench bitrate predictor.
// Depends on lbbe_pkg and the estimator RTL.
module tb_top import lbbe_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 300000;
  localparam int RAND_ITEMS = 700;
  localparam int PHASE_ITEMS = RAND_ITEMS / 5;
  localparam logic [47:0] TMASK = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        status;
    logic [31:0] est;
    logic [31:0] pace;
    logic [16:0] loss;
    logic [16:0] smooth;
    logic        updated;
  } rate_result_t;

  logic         clk, rst_n;
  logic         in_tvalid, in_tready, in_tlast;
  logic [135:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid, out_tready;
  logic [103:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_valid, cfg_ready;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;

  loss_based_bitrate_estimator_core uut (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Predictor state.
  logic [15:0] sz_tab [SEQ_DEPTH];
  bit          sz_ok  [SEQ_DEPTH];
  logic [31:0] lim_min, lim_max, start_rate;
  logic [15:0] own_id;
  logic [31:0] cur_est, cur_pace;
  logic [16:0] loss_fr, smooth_fr;
  bit          have_sample, recv_seen;
  longint unsigned rep_cnt, lost_cnt, acked, t_first, t_latest;

  rate_result_t rate_q[$];
  int errors, items_sent, send_idle, recv_stall, quiet;

  function automatic logic [31:0] clip(longint unsigned v);
    longint unsigned r;
    r = (v < lim_max) ? v : lim_max;
    if (r < lim_min) r = lim_min;
    return r[31:0];
  endfunction

  function automatic longint unsigned mul_q16(longint unsigned v, longint unsigned q);
    longint unsigned r;
    r = (v * q) >> 16;
    return (r > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : r;
  endfunction

  function automatic void drop_report();
    rep_cnt = 0; lost_cnt = 0; acked = 0; t_first = 0; t_latest = 0; recv_seen = 0;
  endfunction

  function automatic void close_report();
    longint unsigned est, rate, dt, w;
    bit has_rate;
    est = cur_est;
    rate = 0;
    has_rate = acked > 0 && recv_seen && t_latest > t_first;
    if (rep_cnt > 0) begin
      loss_fr = 17'((lost_cnt * 65536) / rep_cnt);
      if (!have_sample) begin
        smooth_fr = loss_fr;
        have_sample = 1;
      end else begin
        w = (loss_fr > smooth_fr) ? 22938 : 36045;
        smooth_fr = 17'((64'(smooth_fr) * (65536 - w) + 64'(loss_fr) * w) >> 16);
      end
    end
    if (has_rate) begin
      dt = t_latest - t_first;
      if (dt < 1000) dt = 1000;
      rate = (acked * 8000000) / dt;
      if (rate > 64'hFFFF_FFFF) rate = 64'hFFFF_FFFF;
    end
    if (rep_cnt > 0 && lost_cnt * 20 >= rep_cnt * 6) begin
      est = mul_q16(est, 32768);
    end else if (rep_cnt > 0 && lost_cnt * 20 >= rep_cnt * 3) begin
      est = mul_q16(est, 45875);
    end else if (rep_cnt > 0 && lost_cnt * 20 >= rep_cnt) begin
      est = mul_q16(est, 55706);
    end else if (has_rate) begin
      w = (rate >= est) ? 19661 : 22938;
      if (rate < est / 4) w = 45875;
      else if (rate < est / 2) w = 36045;
      est = (est * (65536 - w) + rate * w) >> 16;
    end else if (rep_cnt == 0 || lost_cnt * 50 < rep_cnt) begin
      est = mul_q16(est, 68813);
    end
    cur_est = clip(est);
    cur_pace = cur_est;
    drop_report();
  endfunction

  function automatic rate_result_t predict_estimate(kind_t k, logic [15:0] seq,
      logic [15:0] nbytes, logic rcv, logic [47:0] t, logic last, logic [15:0] rid,
      logic [31:0] nstart);
    rate_result_t r;
    longint unsigned add;
    r.status = 0;
    r.updated = 0;
    case (k)
      KIND_SENT: begin
        sz_tab[seq] = nbytes;
        sz_ok[seq] = 1;
      end
      KIND_FB: begin
        if (rid != own_id) begin
          r.status = 1;
        end else begin
          if (rep_cnt < 65535) rep_cnt++;
          if (!rcv) begin
            if (lost_cnt < 65535) lost_cnt++;
          end else begin
            add = nbytes;
            if (sz_ok[seq]) begin
              add = sz_tab[seq];
              sz_ok[seq] = 0;
            end
            acked += add;
            if (acked > 64'hFFFF_FFFF) acked = 64'hFFFF_FFFF;
            if (!recv_seen || t < t_first) t_first = t;
            if (!recv_seen || t > t_latest) t_latest = t;
            recv_seen = 1;
          end
          if (last) begin
            close_report();
            r.updated = 1;
          end
        end
      end
      KIND_ROUTE: begin
        cur_est = clip(nstart);
        cur_pace = cur_est;
        foreach (sz_ok[i]) sz_ok[i] = 0;
        smooth_fr = 0;
        have_sample = 0;
        drop_report();
      end
      default: ;
    endcase
    r.est = cur_est;
    r.pace = cur_pace;
    r.loss = loss_fr;
    r.smooth = smooth_fr;
    return r;
  endfunction

  task automatic mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    rate_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (rate_q.size() == 0) begin
        mismatch("unexpected transaction", 0, 0);
      end else begin
        e = rate_q.pop_front();
        if (out_tuser[0] !== e.status) mismatch("status", out_tuser[0], e.status);
        if (out_tuser[1] !== e.updated) mismatch("updated", out_tuser[1], e.updated);
        if (out_tdata[31:0] !== e.est) mismatch("estimate", out_tdata[31:0], e.est);
        if (out_tdata[63:32] !== e.pace) mismatch("pacing", out_tdata[63:32], e.pace);
        if (out_tdata[80:64] !== e.loss) mismatch("loss", out_tdata[80:64], e.loss);
        if (out_tdata[97:81] !== e.smooth) mismatch("smoothed", out_tdata[97:81], e.smooth);
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(kind_t k, logic [15:0] seq, logic [15:0] nbytes, logic rcv,
      logic [47:0] t, logic last, logic [15:0] rid, logic [31:0] nstart);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tlast  <= last;
    in_tdata  <= {7'd0, nstart, rid, t, rcv, nbytes, seq};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rate_q.push_back(predict_estimate(k, seq, nbytes, rcv, t, last, rid, nstart));
    items_sent++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    in_tvalid <= 1'b0;
    while (rate_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MIN_RATE: lim_min = val;
      CFG_MAX_RATE: lim_max = val;
      CFG_START: begin
        start_rate = val;
        cur_est = val;
        cur_pace = val;
      end
      CFG_OWN_ID: own_id = val[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [47:0] rand_time();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // One feedback message for packets sent just before, with a chosen loss level.
  task automatic report_run(int n, int loss_pct);
    logic [15:0] base;
    logic [47:0] t;
    base = 16'($urandom);
    t = rand_time();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8)
        send_item(KIND_SENT, base + 16'(i), 16'($urandom_range(40, 1500)), 0, rand_time(),
                  1'($urandom_range(1)), 16'($urandom), $urandom);
    end
    for (int i = 0; i < n; i++) begin
      t = (t + 48'($urandom_range(0, 20000))) & TMASK;
      send_item(KIND_FB, base + 16'(i), 16'($urandom), $urandom_range(99) >= loss_pct,
                ($urandom_range(9) == 0) ? rand_time() : t, i == n - 1, own_id, $urandom);
    end
  endtask

  task automatic noise_item();
    case ($urandom_range(9))
      0, 1, 2: send_item(KIND_NONE, 16'($urandom), 16'($urandom), 1'($urandom_range(1)),
                         rand_time(), 1'($urandom_range(1)), 16'($urandom), $urandom);
      3, 4, 5: send_item(KIND_FB, 16'($urandom), 16'($urandom), 1'($urandom_range(1)),
                         rand_time(), 1'($urandom_range(1)),
                         own_id ^ 16'($urandom_range(1, 65535)), $urandom);
      6: send_item(KIND_ROUTE, 16'($urandom), 16'($urandom), 1'($urandom_range(1)),
                   rand_time(), 1'($urandom_range(1)), 16'($urandom),
                   $urandom_range(1) ? $urandom : $urandom_range(20000, 3000000));
      default: send_item(KIND_FB, 16'($urandom), 16'($urandom), 1'($urandom_range(1)),
                         rand_time(), 1'($urandom_range(1)), own_id, $urandom);
    endcase
  endtask

  task automatic test_directed();
    send_item(KIND_SENT, 16'h0000, 16'hFFFF, 0, 0, 0, 0, 0);
    send_item(KIND_SENT, 16'hFFFF, 16'h0000, 0, 0, 0, 0, 0);
    send_item(KIND_FB, 16'h0000, 16'h0001, 1, 48'd100, 0, own_id, 0);
    send_item(KIND_FB, 16'hFFFF, 16'hFFFF, 1, TMASK, 1, own_id, 0);
    send_item(KIND_FB, 16'h1234, 16'h0040, 1, 48'd500, 0, own_id, 0);
    send_item(KIND_FB, 16'h1235, 16'h0040, 1, 48'd900, 1, own_id, 0);
    for (int i = 0; i < 3; i++) send_item(KIND_FB, 16'(i), 100, 0, 0, i == 2, own_id, 0);
    for (int i = 0; i < 5; i++) send_item(KIND_FB, 16'(i), 100, i != 0, 48'(i * 3000),
                                          i == 4, own_id, 0);
    send_item(KIND_FB, 0, 0, 1, 0, 1, own_id ^ 16'hFFFF, 0);
    send_item(KIND_FB, 0, 0, 0, 0, 1, own_id, 0);
    send_item(KIND_NONE, 16'hFFFF, 16'hFFFF, 1, TMASK, 1, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(KIND_FB, 5, 500, 1, 48'd10, 0, own_id, 0);
    send_item(KIND_ROUTE, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send_item(KIND_ROUTE, 0, 0, 0, 0, 0, 0, 32'd0);
    send_item(KIND_FB, 7, 1000, 1, 48'd10, 1, own_id, 0);
  endtask

  task automatic test_random(int count, int idle_in, int stall_out);
    int target;
    send_idle = idle_in;
    recv_stall = stall_out;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(9) < 8)
        report_run($urandom_range(1, 24), (int'($urandom_range(4))) * 25 % 101);
      else
        noise_item();
    end
  endtask

  task automatic test_config_corners();
    write_reg(CFG_MIN_RATE, 32'hFFFF_FFFF);
    write_reg(CFG_MAX_RATE, 32'd0);
    write_reg(CFG_START, 32'd0);
    write_reg(CFG_OWN_ID, 32'hFFFF);
    send_item(KIND_FB, 1, 10, 1, 0, 1, 16'hFFFF, 0);
    send_item(KIND_ROUTE, 0, 0, 0, 0, 0, 0, 32'd12345);
    write_reg(CFG_MIN_RATE, 32'd0);
    write_reg(CFG_MAX_RATE, 32'hFFFF_FFFF);
    write_reg(CFG_START, 32'hFFFF_FFFF);
    send_item(KIND_FB, 1, 10, 1, 0, 1, 16'hFFFF, 0);
    test_random(60, 0, 0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 0; in_tdata = '0; in_tuser = '0; in_tlast = 0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0; out_tready = 0;
    errors = 0; items_sent = 0; send_idle = 0; recv_stall = 0; quiet = 0;
    lim_min = RST_MIN; lim_max = RST_MAX; start_rate = RST_START; own_id = '0;
    cur_est = RST_START; cur_pace = RST_START; loss_fr = 0; smooth_fr = 0; have_sample = 0;
    drop_report();
    foreach (sz_ok[i]) sz_ok[i] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(PHASE_ITEMS, 0, 0);
    write_reg(CFG_OWN_ID, 32'h0000_A5C3);
    write_reg(CFG_MIN_RATE, 32'd50000);
    write_reg(CFG_MAX_RATE, 32'd8000000);
    test_random(PHASE_ITEMS, 59, 0);
    write_reg(CFG_START, 32'd1000000);
    test_random(PHASE_ITEMS, 0, 59);
    test_config_corners();
    write_reg(CFG_OWN_ID, 32'h0000_5A3C);
    write_reg(CFG_MIN_RATE, 32'd30000);
    write_reg(CFG_MAX_RATE, 32'd2500000);
    test_random(PHASE_ITEMS, 24, 24);

    in_tvalid <= 1'b0;
    while (rate_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
